FILE: sv/dwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the deadline wakeup table.
// Used by dwt_ctrl, dwt_datapath and deadline_wakeup_table.
package dwt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int MAX_RESULTS     = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WAIT  = 2'd1;
  localparam logic [1:0] CMD_SLEEP = 2'd2;

  localparam logic [1:0] KIND_WOKEN  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  // nsec + duration fits in 41 bits; quotient by 1e9 fits in 12 bits
  localparam int TOTAL_W = 41;
  localparam int QUOT_W  = 12;
  localparam logic [TOTAL_W-1:0] NS_PER_SEC = 41'd1000000000;

  // quotient estimate: ((total >> 20) * floor(2^50 / 1e9)) >> 30, low by at most one
  localparam int EST_SHIFT   = 20;
  localparam int EST_W       = TOTAL_W - EST_SHIFT;
  localparam int RECIP_SHIFT = 30;
  localparam logic [EST_W-1:0] NS_RECIP = 21'd1125899;

  // divide phases, counted down to zero
  localparam int STEP_W     = 2;
  localparam int DIV_PHASES = 3;
  localparam logic [STEP_W-1:0] DIV_PH_EST = 2'd2;
  localparam logic [STEP_W-1:0] DIV_PH_SUB = 2'd1;
  localparam logic [STEP_W-1:0] DIV_PH_FIX = 2'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  waiter_id;
    logic [31:0] time_sec;
    logic [29:0] time_nsec;
    logic [39:0] duration_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] woken_id;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted request
    logic div_step;   // one phase of the divide by 1e9
    logic set_dl;     // deadline = now + quotient, remainder
    logic idx_adv;    // move to the next slot
    logic ins_write;  // store the waiter in the current slot
    logic push_ok;    // present an insert accept
    logic push_full;  // present a table-full reject
    logic wake;       // take the current slot into the pending wakeup
    logic push_pend;  // present the pending wakeup
    logic push_last;  // mark the presented wakeup as last
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic slot_valid;
    logic slot_due;
    logic cnt_full;
    logic pend_v;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/dwt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the deadline wakeup table: decodes requests and steps the
// datapath through divide, free-slot search and expiry scan. Uses dwt_pkg.
module dwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  output logic              in_stall,
  output dwt_pkg::dp_cmd_t  cmd,
  input  dwt_pkg::dp_stat_t stat
);
  import dwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_FIND,
    S_PRIME,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   hit, blocked;

  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    hit       = stat.slot_valid && stat.slot_due && !stat.cnt_full;
    blocked   = hit && stat.pend_v && !stat.out_free;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.load = 1'b1;
          case (in_cmd)
            CMD_TICK:  state_nxt = S_PRIME;
            CMD_WAIT:  state_nxt = S_FIND;
            CMD_SLEEP: state_nxt = S_DIV;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.set_dl = 1'b1;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        if (!stat.slot_valid) begin
          if (stat.out_free) begin
            cmd.ins_write = 1'b1;
            cmd.push_ok   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (stat.idx_last) begin
          if (stat.out_free) begin
            cmd.push_full = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.idx_adv = 1'b1;
        end
      end
      S_PRIME: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // a new hit displaces the pending wakeup, which then goes out unmarked
        if (!blocked) begin
          cmd.idx_adv   = 1'b1;
          cmd.wake      = hit;
          cmd.push_pend = hit && stat.pend_v;
          if (stat.idx_last) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push_pend = 1'b1;
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

endmodule

FILE: sv/dwt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the deadline wakeup table: entry memory, valid bits, divide
// by 1e9, deadline compare, pending wakeup and output register. Uses dwt_pkg.
module dwt_datapath #(
  parameter int TABLE_DEPTH = dwt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_WIDTH    = dwt_pkg::ID_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dwt_pkg::in_item_t  in_data,
  input  dwt_pkg::dp_cmd_t   cmd,
  output dwt_pkg::dp_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output dwt_pkg::out_item_t out_data
);
  import dwt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int ID_EXT = (ID_WIDTH > 8) ? ID_WIDTH : 8;
  localparam int ENT_W = ID_WIDTH + 62;
  localparam int EST_PROD_W = 2 * EST_W;

  // entry word: {id, sec, nsec}
  logic [ENT_W-1:0]       mem [TABLE_DEPTH];
  logic [ENT_W-1:0]       rdata_r;
  logic [IDX_W-1:0]       rd_addr;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [STEP_W-1:0]      k_r;
  logic [TOTAL_W-1:0]     rem_r;
  logic [QUOT_W-1:0]      q_r;
  logic [31:0]            tsec_r;
  logic [29:0]            tnsec_r;
  logic [ID_WIDTH-1:0]    id_r;
  logic                   pend_v_r;
  logic [ID_WIDTH-1:0]    pend_id_r;
  logic                   out_v_r;
  out_item_t              out_r;

  logic [ID_EXT-1:0]      in_id_ext;
  logic [ID_EXT-1:0]      id_ext;
  logic [ID_EXT-1:0]      pend_ext;
  logic [EST_PROD_W-1:0]  est_prod;
  logic [TOTAL_W-1:0]     q_prod;
  logic                   idx_last;
  logic                   out_free;
  logic [ID_WIDTH-1:0]    ent_id;
  logic [31:0]            ent_sec;
  logic [29:0]            ent_nsec;

  assign in_id_ext = ID_EXT'(in_data.waiter_id);
  assign id_ext    = ID_EXT'(id_r);
  assign pend_ext  = ID_EXT'(pend_id_r);
  assign est_prod  = EST_PROD_W'(rem_r[TOTAL_W-1:EST_SHIFT]) * EST_PROD_W'(NS_RECIP);
  assign q_prod    = TOTAL_W'(q_r) * NS_PER_SEC;
  assign idx_last  = (idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign out_free  = !out_v_r || !out_stall;

  assign ent_id   = rdata_r[ENT_W-1 -: ID_WIDTH];
  assign ent_sec  = rdata_r[61:30];
  assign ent_nsec = rdata_r[29:0];

  // read ahead one slot whenever the scan moves on
  assign rd_addr = (cmd.idx_adv && !idx_last) ? idx_r + IDX_W'(1) : idx_r;

  always_comb begin
    stat            = '0;
    stat.div_done   = (k_r == '0);
    stat.idx_last   = idx_last;
    stat.slot_valid = valid_r[idx_r];
    stat.slot_due   = (ent_sec < tsec_r) || ((ent_sec == tsec_r) && (ent_nsec <= tnsec_r));
    stat.cnt_full   = (cnt_r == CNT_W'(MAX_RESULTS));
    stat.pend_v     = pend_v_r;
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) mem[idx_r] <= {id_r, tsec_r, tnsec_r};
    rdata_r <= mem[rd_addr];
  end

  // request latch, divider and deadline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tsec_r  <= in_data.time_sec;
      tnsec_r <= in_data.time_nsec;
      id_r    <= in_id_ext[ID_WIDTH-1:0];
      rem_r   <= TOTAL_W'(in_data.time_nsec) + TOTAL_W'(in_data.duration_ns);
      q_r     <= '0;
    end else if (cmd.div_step) begin
      case (k_r)
        DIV_PH_EST: q_r <= est_prod[RECIP_SHIFT +: QUOT_W];
        DIV_PH_SUB: rem_r <= rem_r - q_prod;
        DIV_PH_FIX: begin
          // estimate may be one low
          if (rem_r >= NS_PER_SEC) begin
            rem_r <= rem_r - NS_PER_SEC;
            q_r   <= q_r + QUOT_W'(1);
          end
        end
        default: ;
      endcase
    end else if (cmd.set_dl) begin
      tsec_r  <= tsec_r + 32'(q_r);
      tnsec_r <= rem_r[29:0];
    end
    if (cmd.wake) pend_id_r <= ent_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
      k_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        cnt_r <= '0;
        k_r   <= STEP_W'(DIV_PHASES - 1);
      end else begin
        if (cmd.idx_adv && !idx_last) idx_r <= idx_r + IDX_W'(1);
        if (cmd.div_step && k_r != '0) k_r <= k_r - STEP_W'(1);
        if (cmd.wake) cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.ins_write) valid_r[idx_r] <= 1'b1;
      if (cmd.wake)      valid_r[idx_r] <= 1'b0;

      if (cmd.wake)           pend_v_r <= 1'b1;
      else if (cmd.push_pend) pend_v_r <= 1'b0;

      if (cmd.push_ok || cmd.push_full || cmd.push_pend) out_v_r <= 1'b1;
      else if (!out_stall)                               out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_ok || cmd.push_full) begin
      out_r.kind     <= cmd.push_ok ? KIND_ACCEPT : KIND_FULL;
      out_r.woken_id <= id_ext[7:0];
      out_r.last     <= 1'b1;
    end else if (cmd.push_pend) begin
      out_r.kind     <= KIND_WOKEN;
      out_r.woken_id <= pend_ext[7:0];
      out_r.last     <= cmd.push_last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: sv/deadline_wakeup_table.sv
`timescale 1ns / 1ps
// Top level of the deadline wakeup table: controller plus datapath.
// Depends on dwt_pkg, dwt_ctrl and dwt_datapath.
//
// Bounded table of sleeping waiters. A wait or sleep request inserts a waiter
// into the lowest free slot and answers with one accept or one table-full
// reject; a sleep first forms its deadline as now plus the duration, which
// takes a divide by 1e9 (reciprocal estimate, back-multiply and subtract,
// one correction) and one add. A tick request removes every valid entry
// whose deadline is at or before the given time (at most MAX_RESULTS per
// tick, lowest slots first) and emits each as a wakeup, the final one
// marked last. Slots are visited one per cycle through the single read
// port of the entry memory, as long as the result side does not stall.
// The next request is taken once the block returns to idle; the last result
// may still sit in the output register.
// Valid bits clear at reset, so no clearing pass is needed.
module deadline_wakeup_table #(
  parameter int TABLE_DEPTH = dwt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_WIDTH    = dwt_pkg::ID_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dwt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dwt_pkg::out_item_t out_data
);
  import dwt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  dwt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
